// ===== src/longest_distinct_run_tracker_defines.svh =====
// Assertion helpers for the distinct-run tracker.
// Both forms are checked on the rising clock edge and switched off while reset is high.
`ifndef LONGEST_DISTINCT_RUN_TRACKER_DEFINES_SVH
`define LONGEST_DISTINCT_RUN_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LDRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define LDRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LDRT_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define LDRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/ldrt_pkg.sv =====
`timescale 1ns / 1ps

package ldrt_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 17;

   localparam longint unsigned MAX_LEN_DEF  = 64'd65536;
   localparam int unsigned     ALPHABET_DEF = 256;

   // table controls for one cycle
   typedef struct packed {
      logic rd_en;   // lookup for the byte being taken in
      logic wr_en;   // record position of the byte leaving the compute stage
      logic clr;     // end of string: forget every byte
   } tbl_ctl_type;

endpackage

// ===== src/longest_distinct_run_tracker.sv =====
// A taken byte waits in the compute stage, then moves into the result register (rsp_valid)
// once that register is free or being emptied. Throughput: one byte per cycle while the
// result side does not stall; the table is read as the byte is taken and written as it
// leaves the compute stage, and a forward register covers a repeat of the byte just before.
// Reset: synchronous, active high; clears the valid bits, window, position, best length,
// overflow flag and both handshake stages. The position memory itself is not cleared.
`timescale 1ns / 1ps
`include "longest_distinct_run_tracker_defines.svh"

module longest_distinct_run_tracker #(
   parameter longint unsigned MAX_LEN  = ldrt_pkg::MAX_LEN_DEF,
   parameter int unsigned     ALPHABET = ldrt_pkg::ALPHABET_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // byte stream in
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ldrt_pkg::BYTE_W-1:0]   req_byte_in,
   input  logic                          req_end_of_string,
   // results out
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ldrt_pkg::LEN_W-1:0]    rsp_window_len,
   output logic [ldrt_pkg::LEN_W-1:0]    rsp_best_len,
   output logic                          rsp_is_final,
   output logic                          rsp_overflow
);
   import ldrt_pkg::*;

   localparam int unsigned SYM_W  = $clog2(ALPHABET);
   localparam int unsigned IDX_W  = $clog2(MAX_LEN);        // stored positions 0..MAX_LEN-1
   localparam int unsigned POS_W  = $clog2(MAX_LEN + 64'd1); // byte count 0..MAX_LEN
   localparam int unsigned EXT_W  = (POS_W > LEN_W) ? POS_W : LEN_W;
   localparam int unsigned NBYTES = 2 ** BYTE_W;

   // ---------------------------------------------------------------------
   // Byte folding into the alphabet: constant table, one entry per byte code
   // ---------------------------------------------------------------------
   logic [SYM_W-1:0] sym_lut [NBYTES];

   for (genvar g = 0; g < NBYTES; g++) begin : g_sym
      localparam int unsigned SYM_VAL = g % ALPHABET;
      assign sym_lut[g] = SYM_VAL[SYM_W-1:0];
   end

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_take;   // input transfer this edge
   logic advance;    // compute stage hands its item to the result register

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // compute-stage payload, held while stalled
   logic [SYM_W-1:0] s1_sym_ff;
   logic             s1_eos_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sym_ff <= sym_lut[req_byte_in];
         s1_eos_ff <= req_end_of_string;
      end
   end

   // ---------------------------------------------------------------------
   // String state
   // ---------------------------------------------------------------------
   logic [POS_W-1:0] pos_ff,  pos_in;
   logic [IDX_W-1:0] ws_ff,   ws_in;
   logic [POS_W-1:0] best_ff, best_in;
   logic             ovf_ff,  ovf_in;

   // table of last positions
   tbl_ctl_type      tbl_ctl;
   logic             seen;
   logic [IDX_W-1:0] last_pos;
   logic             ovf_now;   // byte arrives with the count already at the bound

   assign ovf_now      = (pos_ff == POS_W'(MAX_LEN));
   assign tbl_ctl.rd_en = req_take;
   assign tbl_ctl.wr_en = advance && !ovf_now;
   assign tbl_ctl.clr   = advance && s1_eos_ff;

   ldrt_table #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .rd_sym   (sym_lut[req_byte_in]),
      .look_sym (s1_sym_ff),
      .wr_sym   (s1_sym_ff),
      .wr_pos   (pos_ff[IDX_W-1:0]),
      .seen     (seen),
      .last_pos (last_pos)
   );

   // ---------------------------------------------------------------------
   // Window update
   // ---------------------------------------------------------------------
   logic             repeat_in_win;  // byte last seen inside the current window
   logic [POS_W-1:0] new_ws;
   logic [POS_W-1:0] wlen;
   logic [EXT_W-1:0] wlen_ext;
   logic [EXT_W-1:0] best_ext;

   always_comb begin
      repeat_in_win = seen && (last_pos >= ws_ff);
      new_ws        = repeat_in_win ? (POS_W'(last_pos) + POS_W'(1)) : POS_W'(ws_ff);

      pos_in  = pos_ff;
      ws_in   = ws_ff;
      best_in = best_ff;
      ovf_in  = ovf_ff;

      if (ovf_now) begin
         // dropped byte: report the last window, keep everything else
         wlen   = POS_W'(MAX_LEN) - POS_W'(ws_ff);
         ovf_in = 1'b1;
      end else begin
         wlen   = pos_ff - new_ws + POS_W'(1);
         ws_in  = new_ws[IDX_W-1:0];
         pos_in = pos_ff + POS_W'(1);
         if (wlen > best_ff) begin
            best_in = wlen;
         end
      end

      wlen_ext = EXT_W'(wlen);
      best_ext = EXT_W'(best_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ws_ff   <= '0;
         best_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (advance) begin
         if (s1_eos_ff) begin
            // end of string: start afresh
            pos_ff  <= '0;
            ws_ff   <= '0;
            best_ff <= '0;
            ovf_ff  <= 1'b0;
         end else begin
            pos_ff  <= pos_in;
            ws_ff   <= ws_in;
            best_ff <= best_in;
            ovf_ff  <= ovf_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic [LEN_W-1:0] rsp_window_len_ff;
   logic [LEN_W-1:0] rsp_best_len_ff;
   logic             rsp_is_final_ff;
   logic             rsp_overflow_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_window_len_ff <= wlen_ext[LEN_W-1:0];
         rsp_best_len_ff   <= best_ext[LEN_W-1:0];
         rsp_is_final_ff   <= s1_eos_ff;
         rsp_overflow_ff   <= ovf_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_len = rsp_window_len_ff;
   assign rsp_best_len   = rsp_best_len_ff;
   assign rsp_is_final   = rsp_is_final_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   logic pos_in_bound;  // count never passes the bound
   logic eos_adv;       // end-of-string item leaves the compute stage
   logic state_zero;    // string state back at its reset value
   logic win_chk;       // ordering only holds while counts are not truncated
   logic win_le_best;

   assign pos_in_bound = (pos_ff <= POS_W'(MAX_LEN));
   assign eos_adv      = advance && s1_eos_ff;
   assign state_zero   = (pos_ff == '0) && (best_ff == '0) && (ws_ff == '0) && !ovf_ff;
   assign win_chk      = rsp_valid_ff && (MAX_LEN <= 64'd65536);
   assign win_le_best  = (rsp_window_len_ff <= rsp_best_len_ff);

   `LDRT_ASSERT_NOW(a_pos_bound, clock, reset, 1'b1, pos_in_bound, "byte count beyond bound")
   `LDRT_ASSERT_NEXT(a_eos_clear, clock, reset, eos_adv, state_zero, "state not cleared")
   `LDRT_ASSERT_NOW(a_win_le_best, clock, reset, win_chk, win_le_best, "window beyond best")
   `LDRT_ASSERT_NEXT(a_ovf_sticky, clock, reset, (ovf_ff && !eos_adv), ovf_ff, "overflow dropped")

endmodule

// ===== src/ldrt_table.sv =====
`timescale 1ns / 1ps

module ldrt_table #(
   parameter longint unsigned MAX_LEN  = ldrt_pkg::MAX_LEN_DEF,
   parameter int unsigned     ALPHABET = ldrt_pkg::ALPHABET_DEF,
   localparam int unsigned    SYM_W    = $clog2(ALPHABET),
   localparam int unsigned    IDX_W    = $clog2(MAX_LEN)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ldrt_pkg::tbl_ctl_type   ctl,
   input  logic [SYM_W-1:0]        rd_sym,
   input  logic [SYM_W-1:0]        look_sym,
   input  logic [SYM_W-1:0]        wr_sym,
   input  logic [IDX_W-1:0]        wr_pos,
   output logic                    seen,
   output logic [IDX_W-1:0]        last_pos
);
   import ldrt_pkg::*;

   logic [IDX_W-1:0]    mem [ALPHABET];
   logic [IDX_W-1:0]    rd_data_ff;
   logic [ALPHABET-1:0] valid_ff;
   logic [ALPHABET-1:0] valid_in;
   logic                fwd_valid_ff;
   logic [SYM_W-1:0]    fwd_sym_ff;
   logic [IDX_W-1:0]    fwd_pos_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_sym] <= wr_pos;
      end
   end

   // old contents on a same-edge write; the forward register covers that
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_sym];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_sym] = 1'b1;
      end
      if (ctl.clr) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         fwd_sym_ff <= wr_sym;
         fwd_pos_ff <= wr_pos;
      end
   end

   assign seen     = valid_ff[look_sym];
   assign last_pos = (fwd_valid_ff && (fwd_sym_ff == look_sym)) ? fwd_pos_ff : rd_data_ff;

endmodule

// ===== tb/longest_distinct_run_checker.sv =====
`timescale 1ns / 1ps

module longest_distinct_run_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [ldrt_pkg::BYTE_W-1:0]   req_byte_in,
   input  logic                          req_end_of_string,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [ldrt_pkg::LEN_W-1:0]    rsp_window_len,
   input  logic [ldrt_pkg::LEN_W-1:0]    rsp_best_len,
   input  logic                          rsp_is_final,
   input  logic                          rsp_overflow,
   output int                            mismatches,
   output int                            outstanding
);
   import ldrt_pkg::*;

   localparam longint unsigned MAX_LEN  = MAX_LEN_DEF;
   localparam int unsigned     ALPHABET = ALPHABET_DEF;
   localparam int              SHOWN    = 10;

   typedef struct packed {
      logic [LEN_W-1:0] window_len;
      logic [LEN_W-1:0] best_len;
      logic             is_final;
      logic             overflow;
   } run_result_type;

   // mirror of the tracker state
   logic [15:0]     seen_at [ALPHABET];
   logic            seen    [ALPHABET];
   longint unsigned run_start;
   longint unsigned taken;
   longint unsigned best_run;
   logic            saturated;

   run_result_type  pending_runs [$];

   function automatic void clear_runs();
      foreach (seen[i]) begin
         seen[i]    = 1'b0;
         seen_at[i] = '0;
      end
      run_start = 0;
      taken     = 0;
      best_run  = 0;
      saturated = 1'b0;
   endfunction

   function automatic run_result_type track_byte(input logic [BYTE_W-1:0] b, input logic eos);
      run_result_type  res;
      int unsigned     sym;
      longint unsigned span;
      longint unsigned after_last;
      sym = int'(b) % ALPHABET;
      if (taken >= MAX_LEN) begin
         // saturated: byte dropped, last window reported
         saturated = 1'b1;
         span      = MAX_LEN - run_start;
      end else begin
         after_last = 64'(seen_at[sym]) + 64'd1;
         if (seen[sym] && after_last > run_start)
            run_start = after_last;
         span = taken - run_start + 1;
         if (span > best_run)
            best_run = span;
         seen_at[sym] = taken[15:0];
         seen[sym]    = 1'b1;
         taken++;
      end
      res.window_len = span[LEN_W-1:0];
      res.best_len   = best_run[LEN_W-1:0];
      res.is_final   = eos;
      res.overflow   = saturated;
      if (eos)
         clear_runs();
      return res;
   endfunction

   always @(posedge clock) begin
      run_result_type want;
      if (reset) begin
         clear_runs();
         pending_runs.delete();
         mismatches <= 0;
      end else begin
         if (req_valid && !req_stall)
            pending_runs.push_back(track_byte(req_byte_in, req_end_of_string));
         if (rsp_valid && !rsp_stall) begin
            if (pending_runs.size() == 0) begin
               if (mismatches < SHOWN)
                  $display("%0t: unexpected result window=%0d best=%0d final=%0b ovf=%0b",
                           $time, rsp_window_len, rsp_best_len, rsp_is_final, rsp_overflow);
               mismatches <= mismatches + 1;
            end else begin
               want = pending_runs.pop_front();
               if (rsp_window_len !== want.window_len || rsp_best_len !== want.best_len ||
                   rsp_is_final !== want.is_final || rsp_overflow !== want.overflow) begin
                  if (mismatches < SHOWN)
                     $display("%0t: exp/got win %0d/%0d best %0d/%0d fin %0b/%0b ovf %0b/%0b",
                              $time, want.window_len, rsp_window_len, want.best_len, rsp_best_len,
                              want.is_final, rsp_is_final, want.overflow, rsp_overflow);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
      outstanding <= pending_runs.size();
   end

endmodule

// ===== tb/longest_distinct_run_tracker_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the distinct-run tracker. Prediction and comparison
// live in longest_distinct_run_checker, which sits beside the block and watches
// both channels; this module only feeds strings in, throttles the result side
// and decides pass or fail from the checker's mismatch and outstanding counts.
module longest_distinct_run_tracker_tb;
   import ldrt_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   // Under 1700 transfers in all; the limit is several times what they take even at the longest
   // gap plus the longest stall burst per byte.
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int TAIL_CYCLES  = 8;

   // how the characters of a random string are drawn
   typedef enum int {
      CHARS_NARROW,   // four neighbouring values: frequent repeats
      CHARS_NIBBLE,   // 0..15
      CHARS_ANY,      // full byte range
      CHARS_STRIDE    // odd stride walk: long distinct runs, the odd repeat
   } char_mix_type;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_byte_in       = '0;
   logic                 req_end_of_string = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [LEN_W-1:0]     rsp_window_len;
   logic [LEN_W-1:0]     rsp_best_len;
   logic                 rsp_is_final;
   logic                 rsp_overflow;

   int                   run_errors;
   int                   runs_waiting;
   int                   cycle_count  = 0;

   // idling controls
   logic                 source_quiet = 1'b0;  // sender: no gaps at all
   logic                 sink_quiet   = 1'b0;  // receiver: no stalls at all
   int                   sink_hold    = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   longest_distinct_run_tracker uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_in       (req_byte_in),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_len    (rsp_window_len),
      .rsp_best_len      (rsp_best_len),
      .rsp_is_final      (rsp_is_final),
      .rsp_overflow      (rsp_overflow)
   );

   longest_distinct_run_checker run_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_in       (req_byte_in),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_len    (rsp_window_len),
      .rsp_best_len      (rsp_best_len),
      .rsp_is_final      (rsp_is_final),
      .rsp_overflow      (rsp_overflow),
      .mismatches        (run_errors),
      .outstanding       (runs_waiting)
   );

   // Idle length from three bands: mostly the shortest, now and then the longest.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 92)
         return $urandom_range(4, 8);
      return $urandom_range(12, 30);
   endfunction

   // Receiver back-pressure. A stall burst starts on roughly one free cycle in four;
   // quiet stretches come and go so that some phases run at full rate.
   always @(posedge clock) begin
      if (sink_hold != 0) begin
         rsp_stall <= 1'b1;
         sink_hold <= sink_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!sink_quiet && $urandom_range(0, 3) == 0)
            sink_hold <= idle_cycles();
      end
      if ($urandom_range(0, 199) == 0)
         sink_quiet <= !sink_quiet;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("longest_distinct_run_tracker_tb: done, errors");
         $finish;
      end
   end

   // Push one string through, one transfer per byte, end_of_string on the last.
   // Valid is only dropped for a gap; a byte is held until its transfer completes.
   task automatic send_string(input logic [BYTE_W-1:0] text [$]);
      int gap;
      foreach (text[i]) begin
         gap = 0;
         if (!source_quiet && $urandom_range(0, 9) < 4)
            gap = idle_cycles();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid         <= 1'b1;
         req_byte_in       <= text[i];
         req_end_of_string <= (i == text.size() - 1);
         do @(posedge clock); while (req_stall);
      end
   endtask

   function automatic logic [BYTE_W-1:0] random_char(input char_mix_type mix,
                                                     input logic [BYTE_W-1:0] base,
                                                     input logic [BYTE_W-1:0] stride,
                                                     input int idx);
      logic [31:0] walk;
      case (mix)
         CHARS_NARROW: begin
            walk = base + $urandom_range(0, 3);
         end
         CHARS_NIBBLE: begin
            walk = $urandom_range(0, 15);
         end
         CHARS_ANY: begin
            walk = $urandom_range(0, 255);
         end
         default: begin
            walk = base + idx * stride;
            if ($urandom_range(0, 15) == 0)
               walk = $urandom_range(0, 255);
         end
      endcase
      return walk[BYTE_W-1:0];
   endfunction

   initial begin
      logic [BYTE_W-1:0] text [$];
      logic [BYTE_W-1:0] base;
      logic [BYTE_W-1:0] stride;
      char_mix_type      mix;
      int                len;
      int                sent;
      int                r;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed strings ---
      // single-byte strings at both byte extremes
      send_string('{8'hFF});
      send_string('{8'h00});
      // classic case: repeats inside the window, then a byte repeated straight away
      send_string('{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62});
      // back-to-back repeat of the same byte hits the forwarding path
      send_string('{8'h00, 8'hFF, 8'h00, 8'h00});
      // stale entry: 'a' was last seen before the window start and must not move it
      send_string('{8'h61, 8'h62, 8'h62, 8'h61});
      // alternating bit patterns, two repeats two back
      send_string('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h5A, 8'hA5});

      // --- random strings ---
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            len = $urandom_range(1, 12);
         else if (r < 95)
            len = $urandom_range(13, 60);
         else
            len = $urandom_range(200, 400);
         mix    = char_mix_type'($urandom_range(0, 3));
         base   = BYTE_W'($urandom_range(0, 255));
         stride = BYTE_W'(($urandom_range(0, 127) << 1) | 1);
         text.delete();
         for (int i = 0; i < len; i++)
            text.push_back(random_char(mix, base, stride, i));
         // an occasional string goes through with the sender at full rate
         source_quiet = ($urandom_range(0, 7) == 0);
         send_string(text);
         sent += len;
      end
      req_valid <= 1'b0;
      source_quiet = 1'b0;

      // let the checker's count catch up with the final transfer, then drain
      @(posedge clock);
      while (runs_waiting != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (run_errors == 0 && runs_waiting == 0)
         $display("longest_distinct_run_tracker_tb: done, clean");
      else
         $display("longest_distinct_run_tracker_tb: done, errors");
      $finish;
   end

endmodule
